// ===== hw/rtl/kre_pkg.sv =====
// Package with the types and constants shared by the keyboard report event logic.
`timescale 1ns / 1ps

package kre_pkg;

    // Number of key-code slots in a boot-protocol keyboard report.
    localparam int KEY_SLOTS    = 6;
    localparam int EVENTS       = 2 * KEY_SLOTS;
    localparam int SLOT_W       = $clog2(KEY_SLOTS);
    localparam int QUEUE_DEPTH  = 2;

    // Boot report: modifier byte, reserved byte, then the key slots.
    localparam logic [6:0] REPORT_MIN_LEN   = 7'(2 + KEY_SLOTS);
    // Codes 0 to 3 are no key, rollover, post fail and undefined.
    localparam logic [7:0] LAST_NO_KEY_CODE = 8'h03;
    localparam logic       EV_RELEASE       = 1'b1;
    localparam logic       EV_PRESS         = 1'b0;
    localparam logic [7:0] RELEASE_MODIFIER = 8'h00;

    typedef logic [7:0] key_code_t;

    typedef struct packed {
        logic [6:0] report_length;
        logic [7:0] modifier_bits;
        logic [7:0] key_slot_0;
        logic [7:0] key_slot_1;
        logic [7:0] key_slot_2;
        logic [7:0] key_slot_3;
        logic [7:0] key_slot_4;
        logic [7:0] key_slot_5;
    } kre_in_t;

    typedef struct packed {
        logic [7:0] event_key;
        logic [7:0] event_modifier;
        logic       is_release;
        logic       last_event;
    } kre_out_t;

    // One classified report. Event bit 2*i is the release check of slot i,
    // bit 2*i+1 the press check of slot i, so ascending bit order is output order.
    typedef struct packed {
        logic [7:0]                  modifier;
        key_code_t [KEY_SLOTS-1:0]   old_keys;
        key_code_t [KEY_SLOTS-1:0]   new_keys;
        logic [EVENTS-1:0]           events;
    } kre_job_t;

endpackage

// ===== hw/rtl/kre_front.sv =====
// Front end: accepts reports, compares them with the stored keys and builds event masks.
`timescale 1ns / 1ps

module kre_front import kre_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  kre_in_t  s_data,
    output logic     push_valid,
    input  logic     push_ready,
    output kre_job_t push_job
);

    key_code_t [KEY_SLOTS-1:0] prev_keys_reg;
    key_code_t [KEY_SLOTS-1:0] prev_keys_next;
    key_code_t [KEY_SLOTS-1:0] fresh;
    logic [KEY_SLOTS-1:0]      rel_mask;
    logic [KEY_SLOTS-1:0]      prs_mask;
    logic [EVENTS-1:0]         events;
    logic                      accept;
    logic                      long_report;

    always_comb begin
        fresh[0] = s_data.key_slot_0;
        fresh[1] = s_data.key_slot_1;
        fresh[2] = s_data.key_slot_2;
        fresh[3] = s_data.key_slot_3;
        fresh[4] = s_data.key_slot_4;
        fresh[5] = s_data.key_slot_5;
    end

    // A key is released when it was held and appears in no new slot, and
    // pressed when it is held now and appeared in no previous slot.
    always_comb begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
            logic old_seen;
            logic new_seen;
            old_seen = 1'b0;
            new_seen = 1'b0;
            for (int k = 0; k < KEY_SLOTS; k++) begin
                if (fresh[k] == prev_keys_reg[i]) begin
                    old_seen = 1'b1;
                end
                if (prev_keys_reg[k] == fresh[i]) begin
                    new_seen = 1'b1;
                end
            end
            rel_mask[i] = (prev_keys_reg[i] > LAST_NO_KEY_CODE) && !old_seen;
            prs_mask[i] = (fresh[i] > LAST_NO_KEY_CODE) && !new_seen;
            events[2*i]     = rel_mask[i];
            events[2*i + 1] = prs_mask[i];
        end
    end

    assign long_report = (s_data.report_length >= REPORT_MIN_LEN);
    assign s_ready     = push_ready;
    assign accept      = s_valid && s_ready;
    assign push_valid  = s_valid && long_report && (|events);

    always_comb begin
        push_job.modifier = s_data.modifier_bits;
        push_job.old_keys = prev_keys_reg;
        push_job.new_keys = fresh;
        push_job.events   = events;
    end

    always_comb begin
        prev_keys_next = prev_keys_reg;
        if (accept && long_report) begin
            prev_keys_next = fresh;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_keys_reg <= '0;
        end else begin
            prev_keys_reg <= prev_keys_next;
        end
    end

endmodule

// ===== hw/rtl/kre_queue.sv =====
// Short job queue between the front end and the event sequencer.
`timescale 1ns / 1ps

module kre_queue import kre_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH   // 2 or more
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  kre_job_t in_job,
    output logic     out_valid,
    input  logic     out_ready,
    output kre_job_t out_job
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    kre_job_t           slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_job   = slots_reg[rd_ptr_reg];
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= in_job;
        end
    end

endmodule

// ===== hw/rtl/kre_back.sv =====
// Back end: walks the event mask of one job and emits one key event per cycle while the output accepts them.
`timescale 1ns / 1ps

module kre_back import kre_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     pop_valid,
    output logic     pop_ready,
    input  kre_job_t pop_job,
    output logic     m_valid,
    input  logic     m_ready,
    output kre_out_t m_data
);

    kre_job_t          job_reg;
    kre_job_t          job_next;
    logic              busy_reg;
    logic              busy_next;
    logic [EVENTS-1:0] pend_reg;
    logic [EVENTS-1:0] pend_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    kre_out_t          m_data_reg;
    kre_out_t          m_data_next;

    logic [EVENTS-1:0] lowest;
    logic [EVENTS-1:0] rest;
    logic [SLOT_W-1:0] slot;
    logic              rel;
    logic              advance;
    logic              finishing;
    logic              load;
    kre_out_t          ev;

    // Isolate the lowest pending event, which is the next one in output order.
    assign lowest = pend_reg & (~pend_reg + 1'b1);
    assign rest   = pend_reg & ~lowest;

    always_comb begin
        slot = '0;
        rel  = EV_PRESS;
        for (int j = 0; j < KEY_SLOTS; j++) begin
            if (lowest[2*j]) begin
                slot = SLOT_W'(j);
                rel  = EV_RELEASE;
            end
            if (lowest[2*j + 1]) begin
                slot = SLOT_W'(j);
                rel  = EV_PRESS;
            end
        end
    end

    always_comb begin
        if (rel == EV_RELEASE) begin
            ev.event_key      = job_reg.old_keys[slot];
            ev.event_modifier = RELEASE_MODIFIER;
        end else begin
            ev.event_key      = job_reg.new_keys[slot];
            ev.event_modifier = job_reg.modifier;
        end
        ev.is_release = rel;
        ev.last_event = (rest == '0);
    end

    assign advance   = busy_reg && (!m_valid_reg || m_ready);
    assign finishing = advance && (rest == '0);
    assign pop_ready = !busy_reg || finishing;
    assign load      = pop_valid && pop_ready;

    always_comb begin
        busy_next = busy_reg;
        pend_next = pend_reg;
        job_next  = job_reg;
        if (load) begin
            busy_next = 1'b1;
            pend_next = pop_job.events;
            job_next  = pop_job;
        end else if (finishing) begin
            busy_next = 1'b0;
            pend_next = '0;
        end else if (advance) begin
            pend_next = rest;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (advance) begin
            m_valid_next = 1'b1;
            m_data_next  = ev;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pend_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg    <= job_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hw/rtl/keyboard_report_to_key_events_core.sv =====
// Top level: turns keyboard boot reports into a stream of key press and release events.
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid/s_ready    kre_in_t: length, modifier, six key slots
//  m_        out        m_valid/m_ready    kre_out_t: key, modifier, release flag, last mark
//
// A report is classified in the cycle it is accepted; the queue then holds it until
// the sequencer takes it. The sequencer emits one event per cycle while m_ready is
// high, so a report yields from 0 to 12 events. Short and no-change reports are
// accepted but produce no transfer. Reset (aresetn low, synchronous) clears the
// stored keys, the queue and the output register. Input stalls only when the queue is full.
`timescale 1ns / 1ps

module keyboard_report_to_key_events_core import kre_pkg::*; #(
    parameter int QUEUE_ENTRIES = QUEUE_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  kre_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output kre_out_t m_data
);

    logic     push_valid;
    logic     push_ready;
    kre_job_t push_job;
    logic     pop_valid;
    logic     pop_ready;
    kre_job_t pop_job;

    kre_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    kre_queue #(
        .DEPTH (QUEUE_ENTRIES)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_job    (push_job),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_job   (pop_job)
    );

    kre_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
